/* hdl/beo_pkg.sv */
// Shared types, constants and row functions for the binary erosion block.
`timescale 1ns / 1ps

package beo_pkg;

    // Fixed field widths of the row and configuration channels.
    localparam int ROW_W = 64;
    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] WIDTH_RESET = 7'd64;

    // Depth of the queue between the front and back parts.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // Result kinds on the output channel.
    localparam logic KIND_ROW     = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // One queued command: the beats that one accepted row gives.
    typedef struct packed {
        logic             has_row;
        logic [ROW_W-1:0] row_a;
        logic             has_fin;
        logic [ROW_W-1:0] row_b;
        logic             possible;
    } beo_cmd_t;

    // Which beat of a command the back part sends next.
    typedef enum logic [1:0] {
        PH_ROW_A,
        PH_ROW_B,
        PH_VERDICT
    } beo_phase_t;

    // 3x3 erosion of the middle row; columns outside the mask count as set.
    function automatic logic [ROW_W-1:0] beo_erode(
        input logic [ROW_W-1:0] up,
        input logic [ROW_W-1:0] mid,
        input logic [ROW_W-1:0] down,
        input logic [ROW_W-1:0] m
    );
        logic [ROW_W-1:0] v;
        logic [ROW_W-1:0] e;
        v = (up & mid & down) | ~m;
        e = v & {v[ROW_W-2:0], 1'b1} & {1'b1, v[ROW_W-1:1]};
        return e & m;
    endfunction

    // True when some set pixel of row lies outside the horizontal dilation of x.
    function automatic logic beo_uncovered(
        input logic [ROW_W-1:0] row,
        input logic [ROW_W-1:0] x,
        input logic [ROW_W-1:0] m
    );
        logic [ROW_W-1:0] d;
        d = (x | {x[ROW_W-2:0], 1'b0} | {1'b0, x[ROW_W-1:1]}) & m;
        return |(row & ~d & m);
    endfunction

endpackage

/* hdl/beo_row_if.sv */
// Input channel interface: one image row per beat.
`timescale 1ns / 1ps

interface beo_row_if
    import beo_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] row_bits;
    logic             last_row;

    modport source (output valid, output row_bits, output last_row, input ready);
    modport sink (input valid, input row_bits, input last_row, output ready);
endinterface

/* hdl/beo_result_if.sv */
// Output channel interface: eroded rows and the closing verdict.
`timescale 1ns / 1ps

interface beo_result_if
    import beo_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             result_kind;
    logic [ROW_W-1:0] eroded_row;
    logic             possible;
    logic             last;

    modport source (output valid, output result_kind, output eroded_row,
                    output possible, output last, input ready);
    modport sink (input valid, input result_kind, input eroded_row,
                  input possible, input last, output ready);
endinterface

/* hdl/binary_erosion_opening_check.sv */
// Top level: 3x3 binary erosion of a row stream with an opening check.
//
// Rows enter on row_in, one image row per beat, column j in bit j, with
// last_row on the final row of the image. Results leave on result_out:
// the eroded row of image row i follows the beat of row i+1, and the final
// row yields the last eroded row and then a verdict beat (result_kind set,
// last set, possible set when the 3x3 dilation of the eroded image covers
// every foreground pixel). cfg_we/cfg_wdata write the image width; write it
// only between images.
// A row is taken every cycle while the two-entry command queue has room.
// A result passes the queue and the output register after its row is taken;
// a final row costs up to three output beats, one per cycle while the
// receiver is ready, so the row rate is set by the output port. On a stall
// the output register holds its beat and the queue fills, then row_in.ready
// falls. Reset clears the image state and sets the width to 64 columns.
`timescale 1ns / 1ps

module binary_erosion_opening_check
    import beo_pkg::*;
#(
    parameter int MAX_WIDTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    beo_row_if.sink          row_in,
    beo_result_if.source     result_out,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata
);

    logic     q_push;
    logic     q_pop;
    logic     q_empty;
    logic     q_full;
    beo_cmd_t q_cmd;
    beo_cmd_t q_head;

    // Row intake and erosion.
    beo_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .row_in    (row_in),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    // Decoupling queue.
    beo_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty),
        .full     (q_full)
    );

    // Result sequencing.
    beo_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .result_out (result_out)
    );

endmodule

/* hdl/beo_front.sv */
// Front part: takes rows, erodes them, tracks coverage and queues commands.
`timescale 1ns / 1ps

module beo_front
    import beo_pkg::*;
#(
    parameter int MAX_WIDTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    beo_row_if.sink          row_in,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             q_full,
    output logic             q_push,
    output beo_cmd_t         q_cmd
);

    logic [CFG_W-1:0] width_reg;
    logic [ROW_W-1:0] above_reg, above_next;
    logic [ROW_W-1:0] middle_reg, middle_next;
    logic [ROW_W-1:0] older_reg, older_next;
    logic [ROW_W-1:0] newer_reg, newer_next;
    logic [1:0]       seen_reg, seen_next;
    logic             failed_reg, failed_next;

    logic [CFG_W-1:0] w_eff;
    logic [ROW_W-1:0] mask;
    logic [ROW_W-1:0] cur;
    logic [ROW_W-1:0] e_step;
    logic [ROW_W-1:0] e_fin;
    logic             failed_fin;
    logic             accept;

    assign row_in.ready = !q_full;
    assign accept       = row_in.valid && !q_full;

    // Clamp the configured width and build the column mask.
    always_comb
    begin
        w_eff = width_reg;
        if (w_eff == '0)
        begin
            w_eff = CFG_W'(1);
        end
        else if (w_eff > CFG_W'(MAX_WIDTH))
        begin
            w_eff = CFG_W'(MAX_WIDTH);
        end
        for (int j = 0; j < ROW_W; j++)
        begin
            mask[j] = (CFG_W'(j) < w_eff);
        end
    end

    // Erode the middle row once the row below it arrives, and the final row at the end.
    always_comb
    begin
        cur         = row_in.row_bits & mask;
        e_step      = beo_erode(above_reg, middle_reg, cur, mask);
        above_next  = above_reg;
        middle_next = middle_reg;
        older_next  = older_reg;
        newer_next  = newer_reg;
        failed_next = failed_reg;
        if (seen_reg == 2'd0)
        begin
            // The row above the first one lies outside the image.
            above_next  = mask;
            middle_next = cur;
        end
        else
        begin
            if (seen_reg >= 2'd2)
            begin
                failed_next = failed_reg |
                    beo_uncovered(above_reg & mask, older_reg | newer_reg | e_step, mask);
            end
            older_next  = newer_reg;
            newer_next  = e_step;
            above_next  = middle_reg;
            middle_next = cur;
        end
        seen_next = (seen_reg == 2'd3) ? seen_reg : seen_reg + 2'd1;

        // Flush: the row below the final one lies outside the image.
        e_fin      = beo_erode(above_next, middle_next, mask, mask);
        failed_fin = failed_next |
            beo_uncovered(middle_next & mask, newer_next | e_fin, mask);
        if (seen_next >= 2'd2)
        begin
            failed_fin = failed_fin |
                beo_uncovered(above_next & mask, older_next | newer_next | e_fin, mask);
        end
    end

    // Queue a command whenever the row gives at least one beat.
    assign q_push       = accept && ((seen_reg != 2'd0) || row_in.last_row);
    assign q_cmd.has_row  = (seen_reg != 2'd0);
    assign q_cmd.row_a    = e_step;
    assign q_cmd.has_fin  = row_in.last_row;
    assign q_cmd.row_b    = e_fin;
    assign q_cmd.possible = !failed_fin;

    // Width register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            width_reg <= cfg_wdata;
        end
    end

    // Image state; the final row clears it for the next image.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            above_reg  <= '0;
            middle_reg <= '0;
            older_reg  <= '0;
            newer_reg  <= '0;
            seen_reg   <= '0;
            failed_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (row_in.last_row)
            begin
                above_reg  <= '0;
                middle_reg <= '0;
                older_reg  <= '0;
                newer_reg  <= '0;
                seen_reg   <= '0;
                failed_reg <= 1'b0;
            end
            else
            begin
                above_reg  <= above_next;
                middle_reg <= middle_next;
                older_reg  <= older_next;
                newer_reg  <= newer_next;
                seen_reg   <= seen_next;
                failed_reg <= failed_next;
            end
        end
    end

endmodule

/* hdl/beo_queue.sv */
// Short command queue between the front and back parts.
`timescale 1ns / 1ps

module beo_queue
    import beo_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  beo_cmd_t push_cmd,
    input  logic     pop,
    output beo_cmd_t head,
    output logic     empty,
    output logic     full
);

    beo_cmd_t             slots_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign head  = slots_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + Q_CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - Q_CNT_W'(1);
            end
        end
    end

endmodule

/* hdl/beo_back.sv */
// Back part: turns queued commands into output beats through an output register.
`timescale 1ns / 1ps

module beo_back
    import beo_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  beo_cmd_t     head,
    input  logic         q_empty,
    output logic         q_pop,
    beo_result_if.source result_out
);

    beo_phase_t       phase_reg, phase_next;
    beo_phase_t       phase_eff;
    logic             valid_reg;
    logic             kind_reg, kind_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             possible_reg, possible_next;
    logic             last_reg, last_next;
    logic             load;

    assign result_out.valid       = valid_reg;
    assign result_out.result_kind = kind_reg;
    assign result_out.eroded_row  = row_reg;
    assign result_out.possible    = possible_reg;
    assign result_out.last        = last_reg;

    // A new beat loads when the output register is free or being taken.
    assign load = !q_empty && (!valid_reg || result_out.ready);

    // Beat selection and phase sequencing.
    always_comb
    begin
        phase_eff = phase_reg;
        if (phase_reg == PH_ROW_A && !head.has_row)
        begin
            phase_eff = PH_ROW_B;
        end
        phase_next    = phase_reg;
        q_pop         = 1'b0;
        kind_next     = KIND_ROW;
        row_next      = '0;
        possible_next = 1'b0;
        last_next     = 1'b0;
        unique case (phase_eff)
            PH_ROW_A:
            begin
                row_next = head.row_a;
                if (load)
                begin
                    if (head.has_fin)
                    begin
                        phase_next = PH_ROW_B;
                    end
                    else
                    begin
                        q_pop = 1'b1;
                    end
                end
            end
            PH_ROW_B:
            begin
                row_next = head.row_b;
                if (load)
                begin
                    phase_next = PH_VERDICT;
                end
            end
            PH_VERDICT:
            begin
                kind_next     = KIND_VERDICT;
                possible_next = head.possible;
                last_next     = 1'b1;
                if (load)
                begin
                    q_pop      = 1'b1;
                    phase_next = PH_ROW_A;
                end
            end
            default:
            begin
                phase_next = PH_ROW_A;
            end
        endcase
    end

    // Phase register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_ROW_A;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg     <= kind_next;
            row_reg      <= row_next;
            possible_reg <= possible_next;
            last_reg     <= last_next;
        end
    end

endmodule

/* tb/sv/beo_erosion_checker.sv */
// Checker for the erosion block: predicts the result beats of each row and compares them.
`timescale 1ns / 1ps

module beo_erosion_checker
    import beo_pkg::*;
#(
    parameter int MAX_WIDTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    beo_row_if               row_mon,
    beo_result_if            res_mon,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    output int               mismatches,
    output int               outstanding
);

    // One result beat as it appears on the output channel.
    typedef struct packed {
        logic             kind;
        logic [ROW_W-1:0] row;
        logic             possible;
        logic             last;
    } result_beat_t;

    // Predicted image state, kept apart from the block.
    logic [CFG_W-1:0] width_reg;
    logic [ROW_W-1:0] row_above;
    logic [ROW_W-1:0] row_middle;
    logic [ROW_W-1:0] eroded_older;
    logic [ROW_W-1:0] eroded_newer;
    logic [1:0]       rows_taken;
    logic             cover_broken;
    result_beat_t     expected_beats[$];
    int               fail_count = 0;

    // Columns in use; a width of zero acts as one, anything above the maximum as the maximum.
    function automatic logic [ROW_W-1:0] column_mask(input logic [CFG_W-1:0] w);
        int cols;
        cols = (w == '0) ? 1 : ((int'(w) > MAX_WIDTH) ? MAX_WIDTH : int'(w));
        if (cols >= ROW_W)
            return '1;
        return (ROW_W'(1) << cols) - ROW_W'(1);
    endfunction

    // A pixel survives when all nine neighbors are set; columns outside the image count as set.
    function automatic logic [ROW_W-1:0] erode_row(
        input logic [ROW_W-1:0] up,
        input logic [ROW_W-1:0] mid,
        input logic [ROW_W-1:0] down,
        input logic [ROW_W-1:0] m
    );
        logic [ROW_W-1:0] solid;
        logic [ROW_W-1:0] left_ok;
        logic [ROW_W-1:0] right_ok;
        solid = (up & mid & down) | ~m;
        left_ok = (solid << 1) | ROW_W'(1);
        right_ok = (solid >> 1) | (ROW_W'(1) << (ROW_W - 1));
        return solid & left_ok & right_ok & m;
    endfunction

    // True when a foreground pixel of the row is not reached by the horizontal spread of seeds.
    function automatic logic uncovered(
        input logic [ROW_W-1:0] row,
        input logic [ROW_W-1:0] seeds,
        input logic [ROW_W-1:0] m
    );
        logic [ROW_W-1:0] reach;
        reach = (seeds | (seeds << 1) | (seeds >> 1)) & m;
        return (row & ~reach & m) != '0;
    endfunction

    task automatic clear_image();
        row_above = '0;
        row_middle = '0;
        eroded_older = '0;
        eroded_newer = '0;
        rows_taken = '0;
        cover_broken = 1'b0;
    endtask

    task automatic expect_beat(
        input logic             kind,
        input logic [ROW_W-1:0] row,
        input logic             possible,
        input logic             last
    );
        result_beat_t b;
        b.kind = kind;
        b.row = row;
        b.possible = possible;
        b.last = last;
        expected_beats.push_back(b);
    endtask

    // Advance the image state by one row and queue the beats it causes.
    task automatic absorb_row(input logic [ROW_W-1:0] bits, input logic fin);
        logic [ROW_W-1:0] m;
        logic [ROW_W-1:0] cur;
        logic [ROW_W-1:0] e;
        m = column_mask(width_reg);
        cur = bits & m;
        if (rows_taken == 2'd0)
        begin
            // The row above the first one lies outside the image.
            row_above = m;
            row_middle = cur;
        end
        else
        begin
            e = erode_row(row_above, row_middle, cur, m);
            expect_beat(KIND_ROW, e, 1'b0, 1'b0);
            if (rows_taken >= 2'd2)
                cover_broken |= uncovered(row_above & m, eroded_older | eroded_newer | e, m);
            eroded_older = eroded_newer;
            eroded_newer = e;
            row_above = row_middle;
            row_middle = cur;
        end
        if (rows_taken != 2'd3)
            rows_taken = rows_taken + 2'd1;

        // The final row flushes the last eroded row, checks the tail and gives the verdict.
        if (fin)
        begin
            e = erode_row(row_above, row_middle, m, m);
            expect_beat(KIND_ROW, e, 1'b0, 1'b0);
            if (rows_taken >= 2'd2)
                cover_broken |= uncovered(row_above & m, eroded_older | eroded_newer | e, m);
            cover_broken |= uncovered(row_middle & m, eroded_newer | e, m);
            expect_beat(KIND_VERDICT, '0, !cover_broken, 1'b1);
            clear_image();
        end
    endtask

    // Compare result beats first, then predict from the row taken at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        result_beat_t want;
        if (!rst_n)
        begin
            width_reg = WIDTH_RESET;
            clear_image();
            expected_beats.delete();
            fail_count = 0;
            mismatches <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (res_mon.valid && res_mon.ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    $error("unexpected result beat: result_kind %0d eroded_row %h",
                           res_mon.result_kind, res_mon.eroded_row);
                    fail_count++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (res_mon.result_kind !== want.kind)
                    begin
                        $error("result_kind: expected %0d, got %0d",
                               want.kind, res_mon.result_kind);
                        fail_count++;
                    end
                    if (res_mon.eroded_row !== want.row)
                    begin
                        $error("eroded_row: expected %h, got %h", want.row, res_mon.eroded_row);
                        fail_count++;
                    end
                    if (res_mon.possible !== want.possible)
                    begin
                        $error("possible: expected %0d, got %0d",
                               want.possible, res_mon.possible);
                        fail_count++;
                    end
                    if (res_mon.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, res_mon.last);
                        fail_count++;
                    end
                end
            end
            if (row_mon.valid && row_mon.ready)
                absorb_row(row_mon.row_bits, row_mon.last_row);
            if (cfg_we)
                width_reg = cfg_wdata;
            mismatches <= fail_count;
            outstanding <= expected_beats.size();
        end
    end

endmodule

/* tb/sv/testbench.sv */
// Testbench top: drives rows, width writes and output stalls, and reports the verdict.
`timescale 1ns / 1ps

module testbench;
    import beo_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ROWS = 180;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    int               mismatches;
    int               outstanding;
    int               cycle_count = 0;
    logic             quiet = 1'b0;

    // Image under construction in the random part.
    logic [ROW_W-1:0] seed_rows[0:27];
    logic [ROW_W-1:0] spread;
    int               rows_sent;
    int               height;
    int               pattern;

    beo_row_if    row_if ();
    beo_result_if result_if ();

    binary_erosion_opening_check #(
        .MAX_WIDTH (64)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .row_in     (row_if),
        .result_out (result_if),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    beo_erosion_checker #(
        .MAX_WIDTH (64)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .row_mon     (row_if),
        .res_mon     (result_if),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    // Run guard against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Mostly no gap, some short ones and a few long ones; none while quiet.
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CFG_W-1:0] pick_width();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return CFG_W'($urandom_range(0, 127));
        if (r < 3)
            return CFG_W'(64);
        if (r < 5)
            return CFG_W'($urandom_range(1, 8));
        return CFG_W'($urandom_range(1, 64));
    endfunction

    function automatic logic [ROW_W-1:0] random_row();
        return {$urandom, $urandom};
    endfunction

    // Receiver stalls: ready is dropped for a random gap after each time it is raised.
    initial
    begin
        int stall_left;
        stall_left = 0;
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                result_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_if.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // Offer one row beat after a random gap and hold it until it is taken.
    task automatic send_row(input logic [ROW_W-1:0] bits, input logic fin);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            row_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        row_if.valid <= 1'b1;
        row_if.row_bits <= bits;
        row_if.last_row <= fin;
        @(posedge clk);
        while (!row_if.ready)
            @(posedge clk);
    endtask

    // Stop sending and let every expected beat drain, plus the block's pipeline depth.
    task automatic wait_idle();
        row_if.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_width(input logic [CFG_W-1:0] w);
        cfg_we <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        row_if.valid <= 1'b0;
        row_if.row_bits <= '0;
        row_if.last_row <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-row images at the reset width: full, empty and a lone pixel.
        send_row('1, 1'b1);
        send_row('0, 1'b1);
        send_row(64'h1, 1'b1);

        // Three rows with pixels at both edge columns.
        send_row(64'h8000_0000_0000_0001, 1'b0);
        send_row('1, 1'b0);
        send_row(64'hC000_0000_0000_0003, 1'b1);

        // A solid 3x3 block survives opening.
        send_row('0, 1'b0);
        send_row(64'h1C, 1'b0);
        send_row(64'h1C, 1'b0);
        send_row(64'h1C, 1'b0);
        send_row('0, 1'b1);

        // Width zero behaves as one column.
        wait_idle();
        write_width('0);
        send_row('1, 1'b0);
        send_row('1, 1'b1);

        // Widths above the maximum clamp to it.
        wait_idle();
        write_width('1);
        send_row('1, 1'b0);
        send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
        wait_idle();
        write_width(CFG_W'(65));
        send_row(64'h7FFF_FFFF_FFFF_FFFE, 1'b1);

        // One column: bits beyond the width are dropped.
        wait_idle();
        write_width(CFG_W'(1));
        send_row(64'h1, 1'b0);
        send_row(64'hFFFF_FFFF_FFFF_FFFE, 1'b1);

        wait_idle();
        write_width(CFG_W'(63));
        send_row('1, 1'b0);
        send_row(64'h8000_0000_0000_0000, 1'b0);
        send_row('1, 1'b1);

        // Width changed in the middle of an image.
        wait_idle();
        write_width(CFG_W'(64));
        send_row('1, 1'b0);
        send_row('1, 1'b0);
        wait_idle();
        write_width(CFG_W'(8));
        send_row('1, 1'b1);

        // Random images, some of them opened shapes so that some verdicts pass.
        rows_sent = 0;
        while (rows_sent < RANDOM_ROWS)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                wait_idle();
                write_width(pick_width());
            end
            quiet = ($urandom_range(0, 3) == 0);
            height = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 6);
            pattern = $urandom_range(0, 9);
            for (int i = 0; i < height + 2; i++)
                seed_rows[i] = random_row() & random_row() & random_row() & random_row();
            for (int i = 0; i < height; i++)
            begin
                spread = seed_rows[i] | seed_rows[i + 1] | seed_rows[i + 2];
                spread = spread | (spread << 1) | (spread >> 1);
                case (pattern)
                    4, 5: spread = random_row() | random_row() | random_row();
                    6, 7: spread = random_row();
                    8: spread = spread ^ (ROW_W'(1) << $urandom_range(0, ROW_W - 1));
                    9: spread = ($urandom_range(0, 3) == 0) ? '0 : '1;
                    default: ;
                endcase
                send_row(spread, i == height - 1);
                rows_sent++;
            end
        end
        quiet = 1'b0;

        // Drain and report.
        wait_idle();
        repeat (6) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
